### rtl/core/fenwick_prefix_sum_table_defines.svh
// Assertion macros shared by the prefix-sum table modules
`ifndef FENWICK_PREFIX_SUM_TABLE_DEFINES_SVH
`define FENWICK_PREFIX_SUM_TABLE_DEFINES_SVH

// check while out of reset
`define FPST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define FPST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/fpst_pkg.sv
// Types and constants shared by the prefix-sum table controller and datapath
package fpst_pkg;

  localparam int CMD_W      = 3;
  localparam int IDX_W      = 10;
  localparam int REND_W     = 11;
  localparam int OPER_W     = 32;
  localparam int SUM_W      = 32;
  localparam int POS_W      = 11;
  localparam int CFG_W      = 11;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - SUM_W - POS_W;
  localparam int OUT_USER_W = 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR       = 3'd0,
    CMD_ADD         = 3'd1,
    CMD_SET         = 3'd2,
    CMD_GET         = 3'd3,
    CMD_PREFIX      = 3'd4,
    CMD_RANGE       = 3'd5,
    CMD_LOWER_BOUND = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLR_BOOT,
    S_IDLE,
    S_DISPATCH,
    S_CLR_CMD,
    S_WALK_A,
    S_WALK_B,
    S_UPD,
    S_LB_STEP,
    S_LB_CMP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic walk_a_init;
    logic walk_b_init;
    logic walk_step;
    logic upd_init;
    logic upd_step;
    logic lb_init;
    logic lb_step;
    logic lb_cmp;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             fail;
    logic             clr_last;
    logic             walk_done;
    logic             upd_done;
    logic             lb_done;
    logic             lb_hit;
    logic             out_free;
  } dp_status_t;

endpackage

### rtl/core/fenwick_prefix_sum_table.sv
// Top level of the binary indexed prefix-sum table
//
// One command per transfer; each transfer returns exactly one result. The
// tree lives in a single memory with one read and one write port, so every
// command walks it one node per cycle. Get, prefix sum and range sum run two
// walks of at most log2(n)+1 reads each. Add runs one update walk; set runs
// the walks of a get, then the update walk of an add. Lower bound needs a
// read and a compare per tree level within the configured size. Clear, and
// the clearing pass that follows reset, sweep all MAX_ENTRIES words at one
// per cycle; no command is taken during the pass after reset, while
// configuration writes are.
// A finished result sits in an output register, so the next transfer may be
// accepted before the previous result is taken.
module fenwick_prefix_sum_table #(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // index[9:0], range_end[20:10], operand_value[52:21], zero[55:53]
  input  logic [fpst_pkg::IN_DATA_W-1:0]    s_tdata,
  // command[2:0]
  input  logic [fpst_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // sum_result[31:0], found_position[42:32], zero[47:43]
  output logic [fpst_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status[0]
  output logic [fpst_pkg::OUT_USER_W-1:0]   m_tuser,
  input  logic                              cfg_wen,
  input  logic [fpst_pkg::CFG_W-1:0]        cfg_wdata
);
  import fpst_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [SUM_W-1:0] out_sum;
  logic [POS_W-1:0] out_pos;
  logic             out_status;

  fpst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fpst_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_command   (s_tuser),
    .in_index     (s_tdata[IDX_W-1:0]),
    .in_range_end (s_tdata[IDX_W+REND_W-1:IDX_W]),
    .in_operand   (s_tdata[IDX_W+REND_W+OPER_W-1:IDX_W+REND_W]),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_sum      (out_sum),
    .out_pos      (out_pos),
    .out_status   (out_status)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_pos, out_sum};
  assign m_tuser = out_status;

endmodule

### rtl/core/fpst_ctrl.sv
// Sequencing state machine of the prefix-sum table
`include "fenwick_prefix_sum_table_defines.svh"

module fpst_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fpst_pkg::dp_status_t   status,
  output fpst_pkg::ctrl_cmd_t    cmd
);
  import fpst_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_BOOT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR_BOOT: begin
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status.fail) begin
          state_next = S_RESP;
        end else begin
          case (status.command)
            CMD_CLEAR:       state_next = S_CLR_CMD;
            CMD_ADD:         state_next = S_UPD;
            CMD_LOWER_BOUND: state_next = S_LB_STEP;
            default:         state_next = S_WALK_A;
          endcase
        end
      end
      S_CLR_CMD: begin
        if (status.clr_last) state_next = S_RESP;
      end
      S_WALK_A: begin
        if (status.walk_done) state_next = S_WALK_B;
      end
      S_WALK_B: begin
        if (status.walk_done) begin
          state_next = (status.command == CMD_SET) ? S_UPD : S_RESP;
        end
      end
      S_UPD: begin
        if (status.upd_done) state_next = S_RESP;
      end
      S_LB_STEP: begin
        if (status.lb_done) begin
          state_next = S_RESP;
        end else if (status.lb_hit) begin
          state_next = S_LB_CMP;
        end
      end
      S_LB_CMP: begin
        state_next = S_LB_STEP;
      end
      S_RESP: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLR_BOOT;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLR_BOOT, S_CLR_CMD: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        if (!status.fail) begin
          case (status.command)
            CMD_CLEAR:       cmd.clr_step    = 1'b0;
            CMD_ADD:         cmd.upd_init    = 1'b1;
            CMD_LOWER_BOUND: cmd.lb_init     = 1'b1;
            default:         cmd.walk_a_init = 1'b1;
          endcase
        end
      end
      S_WALK_A: begin
        if (status.walk_done) begin
          cmd.walk_b_init = 1'b1;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_WALK_B: begin
        if (status.walk_done) begin
          cmd.upd_init = (status.command == CMD_SET);
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_UPD: begin
        cmd.upd_step = 1'b1;
      end
      S_LB_STEP: begin
        cmd.lb_step = !status.lb_done;
      end
      S_LB_CMP: begin
        cmd.lb_cmp = 1'b1;
      end
      S_RESP: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `FPST_ASSERT_ALWAYS(a_boot_clear, $past(rst) |-> (state == S_CLR_BOOT), "no clearing pass after reset")
  `FPST_ASSERT(a_accept_dispatch, (state == S_IDLE && in_valid) |=> (state == S_DISPATCH), "accepted transfer not dispatched")
  `FPST_ASSERT(a_resp_idle, (state == S_RESP && status.out_free) |=> (state == S_IDLE), "result load did not return to idle")
  `FPST_ASSERT(a_walk_resp, (state == S_WALK_B && status.walk_done && status.command != CMD_SET) |=> (state == S_RESP), "read command did not respond after second walk")

endmodule

### rtl/core/fpst_dp.sv
// Datapath of the prefix-sum table: tree memory, walk pointers, accumulator, result register
`include "fenwick_prefix_sum_table_defines.svh"

module fpst_dp #(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [fpst_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [fpst_pkg::CMD_W-1:0]    in_command,
  input  logic [fpst_pkg::IDX_W-1:0]    in_index,
  input  logic [fpst_pkg::REND_W-1:0]   in_range_end,
  input  logic [fpst_pkg::OPER_W-1:0]   in_operand,
  input  fpst_pkg::ctrl_cmd_t           cmd,
  output fpst_pkg::dp_status_t          status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fpst_pkg::SUM_W-1:0]    out_sum,
  output logic [fpst_pkg::POS_W-1:0]    out_pos,
  output logic                          out_status
);
  import fpst_pkg::*;

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int PW0 = $clog2(MAX_ENTRIES + 1) + 1;
  localparam int PW  = (PW0 > 12) ? PW0 : 12;
  localparam int VB  = VALUE_BITS;
  localparam int XW  = (VB > SUM_W) ? VB : SUM_W;
  localparam logic [PW-1:0] MAX_P    = PW'(MAX_ENTRIES);
  localparam logic [PW-1:0] K_TOP    = PW'(1) << (PW - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ENTRIES - 1);

  logic [VB-1:0] mem [MAX_ENTRIES];
  logic [VB-1:0] rdata;
  logic [AW-1:0] rd_addr, wa;
  logic [VB-1:0] wd;
  logic          we;

  logic [CFG_W-1:0] cfg_size;
  logic [PW-1:0]    cfg_ext, n;

  logic [CMD_W-1:0] cmd_q;
  logic [PW-1:0]    idx_q, rend_q;
  logic [VB-1:0]    oper_q;
  logic [XW-1:0]    oper_x;

  logic [PW-1:0] ptr, pos, k;
  logic [VB-1:0] acc, p1, delta;
  logic          vld_d;
  logic [AW-1:0] wa_d, clr_addr;

  logic          fail;
  logic [PW-1:0] idx_inc, start_a, start_b, low_bit, ptr_m1, lb_sum, lb_m1;
  logic [AW-1:0] ptr_addr, lb_addr;
  logic [VB-1:0] lb_t, sum_val;
  logic [XW-1:0] sum_x;
  logic          lb_hit;

  assign cfg_ext = PW'(cfg_size);

  always_comb begin
    n = cfg_ext;
    if (cfg_ext == '0) begin
      n = PW'(1);
    end else if (cfg_ext > MAX_P) begin
      n = MAX_P;
    end
  end

  assign oper_x = XW'($signed(in_operand));

  always_comb begin
    if (cmd_q inside {CMD_ADD, CMD_SET, CMD_GET}) begin
      fail = (idx_q >= n);
    end else if (cmd_q == CMD_RANGE) begin
      fail = (idx_q >= rend_q);
    end else if (cmd_q inside {CMD_CLEAR, CMD_PREFIX, CMD_LOWER_BOUND}) begin
      fail = 1'b0;
    end else begin
      fail = 1'b1;
    end
  end

  assign idx_inc = idx_q + PW'(1);

  always_comb begin
    if (cmd_q == CMD_RANGE) begin
      start_a = (rend_q > n) ? n : rend_q;
    end else begin
      start_a = (idx_inc > n) ? n : idx_inc;
    end
    if (cmd_q == CMD_PREFIX) begin
      start_b = '0;
    end else begin
      start_b = (idx_q > n) ? n : idx_q;
    end
  end

  assign low_bit  = ptr & (~ptr + PW'(1));
  assign ptr_m1   = ptr - PW'(1);
  assign ptr_addr = ptr_m1[AW-1:0];
  assign lb_sum   = pos + k;
  assign lb_m1    = lb_sum - PW'(1);
  assign lb_addr  = lb_m1[AW-1:0];
  assign lb_hit   = (lb_sum <= n);
  assign lb_t     = acc + rdata;

  assign rd_addr = cmd.lb_step ? lb_addr : ptr_addr;
  assign we      = cmd.clr_step || (cmd.upd_step && vld_d);
  assign wa      = cmd.clr_step ? clr_addr : wa_d;
  assign wd      = cmd.clr_step ? '0 : (rdata + delta);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size  <= CFG_RESET;
      clr_addr  <= '0;
      vld_d     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) cfg_size <= cfg_wdata;
      if (cmd.clr_step) begin
        clr_addr <= (clr_addr == CLR_LAST) ? '0 : (clr_addr + AW'(1));
      end
      if (cmd.walk_a_init || cmd.walk_b_init || cmd.upd_init) begin
        vld_d <= 1'b0;
      end else if (cmd.walk_step) begin
        vld_d <= (ptr != '0);
      end else if (cmd.upd_step) begin
        vld_d <= (ptr <= n);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sum_val = ((cmd_q inside {CMD_GET, CMD_PREFIX, CMD_RANGE}) && !fail) ? (p1 - acc) : '0;
  assign sum_x   = XW'($signed(sum_val));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= in_command;
      idx_q  <= PW'(in_index);
      rend_q <= PW'(in_range_end);
      oper_q <= oper_x[VB-1:0];
    end
    if (cmd.walk_a_init) begin
      ptr <= start_a;
      acc <= '0;
    end
    if (cmd.walk_b_init) begin
      ptr <= start_b;
      acc <= '0;
      p1  <= acc;
    end
    if (cmd.walk_step) begin
      if (ptr != '0) begin
        ptr  <= ptr - low_bit;
        wa_d <= ptr_addr;
      end
      if (vld_d) acc <= acc + rdata;
    end
    if (cmd.upd_init) begin
      ptr   <= idx_inc;
      delta <= (cmd_q == CMD_SET) ? (oper_q - (p1 - acc)) : oper_q;
    end
    if (cmd.upd_step && (ptr <= n)) begin
      ptr  <= ptr + low_bit;
      wa_d <= ptr_addr;
    end
    if (cmd.lb_init) begin
      pos <= '0;
      k   <= K_TOP;
      acc <= '0;
    end
    if (cmd.lb_step && !lb_hit) begin
      k <= k >> 1;
    end
    if (cmd.lb_cmp) begin
      if ($signed(lb_t) < $signed(oper_q)) begin
        pos <= lb_sum;
        acc <= lb_t;
      end
      k <= k >> 1;
    end
    if (cmd.out_load) begin
      out_sum    <= sum_x[SUM_W-1:0];
      out_pos    <= (cmd_q == CMD_LOWER_BOUND) ? pos[POS_W-1:0] : '0;
      out_status <= fail;
    end
  end

  always_comb begin
    status           = '0;
    status.command   = cmd_q;
    status.fail      = fail;
    status.clr_last  = (clr_addr == CLR_LAST);
    status.walk_done = (ptr == '0) && !vld_d;
    status.upd_done  = (ptr > n) && !vld_d;
    status.lb_done   = (k == '0);
    status.lb_hit    = lb_hit;
    status.out_free  = !out_valid || out_ready;
  end

  `FPST_ASSERT(a_pipe_addr, vld_d |-> (PW'(wa_d) < n), "tree access beyond configured size")
  `FPST_ASSERT(a_clr_wrap, (cmd.clr_step && clr_addr == CLR_LAST) |=> (clr_addr == '0), "clear sweep did not wrap")

endmodule
